/* hdl/framed_command_packet_parser_top_assert.svh */
// Assertion macros shared by the packet parser modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FRAMED_COMMAND_PACKET_PARSER_TOP_ASSERT_SVH
`define FRAMED_COMMAND_PACKET_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define FCPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCPP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fcpp_pkg.sv */
// Shared types and constants of the framed command packet parser.
// No dependencies; the interface and module files refer to it by scoped names.
package fcpp_pkg;

	localparam logic [7:0] SOF1 = 8'hAA;
	localparam logic [7:0] SOF2 = 8'h55;

	localparam logic [7:0] FN_01 = 8'h01;
	localparam logic [7:0] FN_03 = 8'h03;
	localparam logic [7:0] FN_05 = 8'h05;
	localparam logic [7:0] FN_07 = 8'h07;
	localparam logic [7:0] FN_11 = 8'h11;
	localparam logic [7:0] FN_13 = 8'h13;

	localparam int unsigned MAX_PAYLOAD_DEF = 32;
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned STORE_DEPTH     = 32;
	localparam int unsigned BANKS           = 2;
	localparam int unsigned ADDR_W          = 6;
	localparam int unsigned QUEUE_DEPTH     = 2;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// frame verdict passed from parser to emitter
	typedef struct packed {
		logic             ok;
		logic [7:0]       func;
		logic [LEN_W-1:0] len;
		logic             bank;
	} cmd_t;

	// payload store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic             kind;
		logic             frame_ok;
		logic [7:0]       func_code;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       payload_byte;
		logic             last;
	} res_t;

endpackage

/* hdl/fcpp_if.sv */
// Handshake channels of the packet parser: received bytes in, results out.
// Depends on fcpp_pkg for the length width.
interface fcpp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcpp_res_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic                          frame_ok;
	logic [7:0]                    func_code;
	logic [fcpp_pkg::LEN_W-1:0]    payload_length;
	logic [7:0]                    payload_byte;
	logic                          last;

	modport source (output valid, output kind, output frame_ok, output func_code,
		output payload_length, output payload_byte, output last, input ready);
	modport sink (input valid, input kind, input frame_ok, input func_code,
		input payload_length, input payload_byte, input last, output ready);
endinterface

/* hdl/fcpp_cmd_queue.sv */
// Two-entry queue of frame verdicts between parser and emitter.
// Depends on fcpp_pkg and the assertion macro header.
`include "framed_command_packet_parser_top_assert.svh"

module fcpp_cmd_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  fcpp_pkg::cmd_t                push_cmd,
	output logic                          full,
	input  logic                          pop,
	output fcpp_pkg::cmd_t                head,
	output logic                          head_valid,
	output logic [fcpp_pkg::BANKS-1:0]    bank_busy
);

	localparam logic [1:0] CNT_FULL = 2'(fcpp_pkg::QUEUE_DEPTH);

	fcpp_pkg::cmd_t ent_q [fcpp_pkg::QUEUE_DEPTH];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rp_q];

	// a bank stays busy while a queued good frame with payload still points at it
	always_comb begin
		bank_busy = '0;
		for (int i = 0; i < int'(fcpp_pkg::QUEUE_DEPTH); i++) begin
			if ((cnt_q == CNT_FULL || (cnt_q == 2'd1 && rp_q == 1'(i))) &&
				ent_q[i].ok && ent_q[i].len != '0) begin
				bank_busy[ent_q[i].bank] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`FCPP_ASSERT_IMP(a_q_no_overflow, push, cnt_q != CNT_FULL, "verdict queue overflow")
	`FCPP_ASSERT_IMP(a_q_no_underflow, pop, cnt_q != 2'd0, "verdict queue underflow")
	`FCPP_ASSERT_NXT(a_q_count_up, push && !pop, cnt_q == $past(cnt_q) + 2'd1,
		"queue count did not advance on push")

endmodule

/* hdl/fcpp_front.sv */
// Byte parser: walks the frame format, checks the sum, stores payload words.
// Depends on fcpp_pkg and the fcpp_rx_if channel.
module fcpp_front #(
	parameter int unsigned MAX_PAYLOAD = fcpp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fcpp_rx_if.sink                       rx,
	input  logic                          q_full,
	input  logic [fcpp_pkg::BANKS-1:0]    bank_busy,
	output logic                          push,
	output fcpp_pkg::cmd_t                push_cmd,
	output fcpp_pkg::wr_t                 wr
);

	typedef enum logic [2:0] {
		PH_START1,
		PH_START2,
		PH_FUNC,
		PH_LEN,
		PH_DATA,
		PH_CHECK
	} phase_t;

	localparam logic [7:0] MAX_LEN_B  = 8'(MAX_PAYLOAD);
	localparam logic [7:0] STORE_LIM  = 8'(fcpp_pkg::STORE_DEPTH);

	phase_t                       phase_q;
	logic [7:0]                   func_q;
	logic [fcpp_pkg::LEN_W-1:0]   len_q;
	logic [fcpp_pkg::LEN_W-1:0]   cnt_q;
	logic [7:0]                   sum_q;
	logic                         bank_q;
	logic                         take;
	logic                         stall;
	logic [7:0]                   b;
	logic                         sum_ok;

	assign b      = rx.rx_byte;
	assign stall  = ((phase_q == PH_DATA) && bank_busy[bank_q]) ||
		((phase_q == PH_CHECK) && q_full);
	assign rx.ready = !stall;
	assign take   = rx.valid && !stall;
	assign sum_ok = (~sum_q == b);

	assign push     = take && (phase_q == PH_CHECK);
	assign push_cmd = '{ok: sum_ok, func: func_q, len: len_q, bank: bank_q};

	assign wr.en   = take && (phase_q == PH_DATA);
	assign wr.addr = {bank_q, cnt_q};
	assign wr.data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START1;
			func_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			bank_q  <= 1'b0;
		end else if (take) begin
			case (phase_q)
				PH_START2: begin
					phase_q <= (b == fcpp_pkg::SOF2) ? PH_FUNC : PH_START1;
				end
				PH_FUNC: begin
					if (b inside {fcpp_pkg::FN_01, fcpp_pkg::FN_03, fcpp_pkg::FN_05,
						fcpp_pkg::FN_07, fcpp_pkg::FN_11, fcpp_pkg::FN_13}) begin
						func_q  <= b;
						sum_q   <= b;
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_START1;
					end
				end
				PH_LEN: begin
					// oversize length: drop and treat this word as a fresh start byte
					if (b >= MAX_LEN_B || b >= STORE_LIM) begin
						phase_q <= (b == fcpp_pkg::SOF1) ? PH_START2 : PH_START1;
					end else begin
						len_q   <= b[fcpp_pkg::LEN_W-1:0];
						sum_q   <= sum_q + b;
						cnt_q   <= '0;
						phase_q <= (b == 8'd0) ? PH_CHECK : PH_DATA;
					end
				end
				PH_DATA: begin
					sum_q <= sum_q + b;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1'b1 == len_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					// a good frame with payload hands its bank to the emitter
					if (sum_ok && len_q != '0) begin
						bank_q <= ~bank_q;
					end
					func_q  <= '0;
					len_q   <= '0;
					cnt_q   <= '0;
					sum_q   <= '0;
					phase_q <= PH_START1;
				end
				default: begin
					phase_q <= (b == fcpp_pkg::SOF1) ? PH_START2 : PH_START1;
				end
			endcase
		end
	end

endmodule

/* hdl/fcpp_back.sv */
// Result emitter: turns queued verdicts into header and payload results.
// Holds the two-bank payload store; depends on fcpp_pkg, fcpp_res_if, macros.
`include "framed_command_packet_parser_top_assert.svh"

module fcpp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fcpp_pkg::wr_t   wr,
	input  fcpp_pkg::cmd_t  head,
	input  logic            head_valid,
	output logic            pop,
	fcpp_res_if.source      res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEND,
		S_LOAD
	} state_t;

	localparam int unsigned MEM_DEPTH = fcpp_pkg::BANKS * fcpp_pkg::STORE_DEPTH;

	logic [7:0]                  mem [MEM_DEPTH];
	logic [7:0]                  rd_q;
	state_t                      state_q;
	logic [fcpp_pkg::LEN_W-1:0]  idx_q;
	fcpp_pkg::res_t              out_q;
	logic                        taken;

	assign taken = (state_q == S_SEND) && res.ready;
	assign pop   = taken && out_q.last;

	assign res.valid          = (state_q == S_SEND);
	assign res.kind           = out_q.kind;
	assign res.frame_ok       = out_q.frame_ok;
	assign res.func_code      = out_q.func_code;
	assign res.payload_length = out_q.payload_length;
	assign res.payload_byte   = out_q.payload_byte;
	assign res.last           = out_q.last;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[{head.bank, idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			out_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						out_q.kind           <= fcpp_pkg::KIND_HEADER;
						out_q.frame_ok       <= head.ok;
						out_q.func_code      <= head.func;
						out_q.payload_length <= head.len;
						out_q.payload_byte   <= 8'd0;
						out_q.last           <= !head.ok || (head.len == '0);
						idx_q                <= '0;
						state_q              <= S_SEND;
					end
				end
				S_SEND: begin
					if (taken) begin
						// read word idx_q is captured on this edge
						state_q <= out_q.last ? S_IDLE : S_LOAD;
					end
				end
				S_LOAD: begin
					out_q.kind         <= fcpp_pkg::KIND_PAYLOAD;
					out_q.payload_byte <= rd_q;
					out_q.last         <= (idx_q + 1'b1 == head.len);
					idx_q              <= idx_q + 1'b1;
					state_q            <= S_SEND;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FCPP_ASSERT_IMP(a_load_needs_payload, state_q == S_LOAD,
		head_valid && head.ok && head.len != '0, "payload fetch without a good frame")
	`FCPP_ASSERT_IMP(a_no_write_to_read_bank,
		wr.en && head_valid && head.ok && head.len != '0 && state_q != S_IDLE,
		wr.addr[fcpp_pkg::ADDR_W-1] != head.bank, "parser wrote the bank being emitted")
	`FCPP_ASSERT_IMP(a_payload_index_bound,
		state_q == S_SEND && out_q.kind == fcpp_pkg::KIND_PAYLOAD,
		idx_q != '0 && idx_q <= head.len, "payload index outside frame length")

endmodule

/* hdl/framed_command_packet_parser_top.sv */
// The header result is registered from the queue head once the checksum word is taken.
// One received word is taken per cycle while not stalled; the registered read of the
// payload store feeds the output register, one payload result at a time.
// The parser stalls only when both payload banks or both verdict slots are in use.
// Reset (arst_n low, asynchronous) clears all control state; the payload store is
// not cleared and needs no clearing pass.
module framed_command_packet_parser_top #(
	parameter int unsigned MAX_PAYLOAD = fcpp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fcpp_rx_if.sink     rx_ch,
	fcpp_res_if.source  res_ch
);

	logic                              push;
	logic                              pop;
	logic                              q_full;
	logic                              head_valid;
	logic [fcpp_pkg::BANKS-1:0]        bank_busy;
	fcpp_pkg::cmd_t                    push_cmd;
	fcpp_pkg::cmd_t                    head;
	fcpp_pkg::wr_t                     wr;

	fcpp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.q_full    (q_full),
		.bank_busy (bank_busy),
		.push      (push),
		.push_cmd  (push_cmd),
		.wr        (wr)
	);

	fcpp_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.bank_busy  (bank_busy)
	);

	fcpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res_ch)
	);

endmodule
